>>> hdl/izoc_pkg.sv
`default_nettype none

package izoc_pkg;

  localparam int unsigned SMP_W      = 16;
  localparam int unsigned GRAV_W     = 15;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned N_AXES     = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned STABLE_COUNT_DEF  = 50;
  localparam int unsigned AVERAGE_COUNT_DEF = 50;

  localparam logic signed [SMP_W-1:0] THRESHOLD_RST = 16'sd300;
  localparam logic [GRAV_W-1:0]       GRAVITY_RST   = 15'd16384;

  // Fraction bits of the reciprocal used for the division by the sample count.
  localparam int unsigned RECIP_SHIFT = SUM_W;

  // Axis order within a sample and within the offsets.
  localparam int unsigned AX_RATE_X = 0;
  localparam int unsigned AX_RATE_Y = 1;
  localparam int unsigned AX_RATE_Z = 2;
  localparam int unsigned AX_ACC_X  = 3;
  localparam int unsigned AX_ACC_Y  = 4;
  localparam int unsigned AX_ACC_Z  = 5;

  typedef enum logic [PHASE_W-1:0] {
    PH_WAIT  = 2'd0,
    PH_AVG   = 2'd1,
    PH_READY = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_GRAVITY   = 1'b1
  } cfg_idx_e;

  typedef logic [N_AXES-1:0][SMP_W-1:0] smp_vec_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [OFF_W-1:0]      off_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_quot;
  } div_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/izoc_if.sv
`default_nettype none

interface izoc_smp_if import izoc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    restart;
  logic signed [SMP_W-1:0] rate_x;
  logic signed [SMP_W-1:0] rate_y;
  logic signed [SMP_W-1:0] rate_z;
  logic signed [SMP_W-1:0] acc_x;
  logic signed [SMP_W-1:0] acc_y;
  logic signed [SMP_W-1:0] acc_z;

  modport source (output valid, restart, rate_x, rate_y, rate_z, acc_x, acc_y, acc_z,
                  input ready);
  modport sink   (input valid, restart, rate_x, rate_y, rate_z, acc_x, acc_y, acc_z,
                  output ready);
endinterface

interface izoc_res_if import izoc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [PHASE_W-1:0]      phase;
  logic signed [OFF_W-1:0] rate_off_x;
  logic signed [OFF_W-1:0] rate_off_y;
  logic signed [OFF_W-1:0] rate_off_z;
  logic signed [OFF_W-1:0] acc_off_x;
  logic signed [OFF_W-1:0] acc_off_y;
  logic signed [OFF_W-1:0] acc_off_z;

  modport source (output valid, phase, rate_off_x, rate_off_y, rate_off_z,
                  acc_off_x, acc_off_y, acc_off_z, input ready);
  modport sink   (input valid, phase, rate_off_x, rate_off_y, rate_off_z,
                  acc_off_x, acc_off_y, acc_off_z, output ready);
endinterface

interface izoc_cfg_if import izoc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/izoc_tracker.sv
`default_nettype none

module izoc_tracker import izoc_pkg::*; #(
  parameter int unsigned STABLE_COUNT  = STABLE_COUNT_DEF,
  parameter int unsigned AVERAGE_COUNT = AVERAGE_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic                    restart_i,
  input  smp_vec_t                smp_i,
  input  logic signed [SMP_W-1:0] thr_i,
  input  logic [GRAV_W-1:0]       grav_i,
  output phase_e                  phase_o,
  output logic                    done_o,
  output sum_t                    sums_o [N_AXES]
);

  localparam int unsigned ADD_W = SMP_W + 2;
  localparam logic [CNT_W-1:0] STABLE_N = CNT_W'(STABLE_COUNT);
  localparam logic [CNT_W-1:0] AVG_N    = CNT_W'(AVERAGE_COUNT);
  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   stb_cnt_q, stb_cnt_d;
  logic [CNT_W-1:0]   avg_cnt_q, avg_cnt_d;
  sum_t               sums_q [N_AXES];
  sum_t               sums_d [N_AXES];
  sum_t               sums_acc [N_AXES];

  phase_e             phase2_q;
  logic               done2_q;
  sum_t               sums2_q [N_AXES];

  logic               stable;
  logic [CNT_W-1:0]   stb_inc, avg_inc;
  logic               stb_full, avg_full;
  logic               done;
  logic signed [ADD_W-1:0] acc_z_net;
  logic signed [ADD_W-1:0] addend [N_AXES];
  logic signed [SUM_W:0]   wide [N_AXES];

  assign stable = ($signed(smp_i[AX_RATE_X]) < thr_i) &&
                  ($signed(smp_i[AX_RATE_Y]) < thr_i) &&
                  ($signed(smp_i[AX_RATE_Z]) < thr_i);

  assign stb_inc  = stb_cnt_q + 1'b1;
  assign avg_inc  = avg_cnt_q + 1'b1;
  assign stb_full = stb_inc >= STABLE_N;
  assign avg_full = avg_inc >= AVG_N;

  assign acc_z_net = ADD_W'($signed(smp_i[AX_ACC_Z])) - $signed({3'b000, grav_i});

  // Saturating accumulation; a 25-bit sum shows overflow in its two top bits.
  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      addend[i] = (i == AX_ACC_Z) ? acc_z_net : ADD_W'($signed(smp_i[i]));
      wide[i]   = (SUM_W+1)'(sums_q[i]) + (SUM_W+1)'(addend[i]);
      if (wide[i][SUM_W] != wide[i][SUM_W-1]) begin
        sums_acc[i] = wide[i][SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        sums_acc[i] = wide[i][SUM_W-1:0];
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    stb_cnt_d = stb_cnt_q;
    avg_cnt_d = avg_cnt_q;
    sums_d    = sums_q;
    if (restart_i) begin
      phase_d   = PH_WAIT;
      stb_cnt_d = '0;
      avg_cnt_d = '0;
      for (int i = 0; i < N_AXES; i++) begin
        sums_d[i] = '0;
      end
    end else begin
      case (phase_q)
        PH_WAIT: begin
          if (stable) begin
            stb_cnt_d = stb_inc;
            if (stb_full) begin
              phase_d = PH_AVG;
            end
          end
        end
        PH_AVG: begin
          sums_d    = sums_acc;
          avg_cnt_d = avg_inc;
          if (avg_full) begin
            phase_d = PH_READY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    done = !restart_i && (phase_q == PH_AVG) && avg_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      stb_cnt_q <= '0;
      avg_cnt_q <= '0;
      for (int i = 0; i < N_AXES; i++) begin
        sums_q[i] <= '0;
      end
    end else if (step_i) begin
      phase_q   <= phase_d;
      stb_cnt_q <= stb_cnt_d;
      avg_cnt_q <= avg_cnt_d;
      sums_q    <= sums_d;
    end
  end

  // Snapshot for the divider stages, so that the next sample may update the state.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      phase2_q <= phase_d;
      done2_q  <= done;
      sums2_q  <= sums_d;
    end
  end

  assign phase_o = phase2_q;
  assign done_o  = done2_q;
  assign sums_o  = sums2_q;

endmodule

`default_nettype wire

>>> hdl/izoc_div.sv
`default_nettype none

module izoc_div import izoc_pkg::*; #(
  parameter int unsigned AVERAGE_COUNT = AVERAGE_COUNT_DEF
) (
  input  logic      clk_i,
  input  div_ctrl_t ctrl_i,
  input  sum_t      sum_i,
  output off_t      off_o
);

  localparam int unsigned MAG_W   = SUM_W;
  localparam int unsigned RECIP_W = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;
  localparam int unsigned QN_W    = MAG_W + CNT_W;
  localparam int unsigned REM_W   = CNT_W + 1;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / AVERAGE_COUNT);
  localparam logic [CNT_W-1:0]   DIV_N = CNT_W'(AVERAGE_COUNT);
  localparam logic [MAG_W-1:0]   POS_LIM = MAG_W'((1 << (OFF_W-1)) - 1);
  localparam logic [MAG_W-1:0]   NEG_LIM = MAG_W'(1 << (OFF_W-1));
  localparam off_t OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
  localparam off_t OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod_d;
  logic              neg3_q;
  logic [MAG_W-1:0]  mag3_q;
  logic [PROD_W-1:0] prod3_q;

  logic [MAG_W-1:0]  qest;
  logic [QN_W-1:0]   qn;
  logic [QN_W-1:0]   diff;
  logic              neg4_q;
  logic [MAG_W-1:0]  qest4_q;
  logic [REM_W-1:0]  rem4_q;

  logic [MAG_W-1:0]  qfix;
  logic [MAG_W-1:0]  qneg;

  // The reciprocal estimate is never above the true quotient and at most one below.
  assign mag    = sum_i[SUM_W-1] ? MAG_W'(-sum_i) : MAG_W'(sum_i);
  assign prod_d = PROD_W'(mag) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod) begin
      neg3_q  <= sum_i[SUM_W-1];
      mag3_q  <= mag;
      prod3_q <= prod_d;
    end
  end

  assign qest = prod3_q[RECIP_SHIFT +: MAG_W];
  assign qn   = QN_W'(qest) * QN_W'(DIV_N);
  assign diff = QN_W'(mag3_q) - qn;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_quot) begin
      neg4_q  <= neg3_q;
      qest4_q <= qest;
      rem4_q  <= diff[REM_W-1:0];
    end
  end

  assign qfix = qest4_q + MAG_W'(rem4_q >= REM_W'(DIV_N));
  assign qneg = -qfix;

  always_comb begin
    if (neg4_q) begin
      off_o = (qfix > NEG_LIM) ? OFF_MIN : qneg[OFF_W-1:0];
    end else begin
      off_o = (qfix > POS_LIM) ? OFF_MAX : qfix[OFF_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/imu_zero_offset_calibrator.sv
// Each sample passes the input register, state update, reciprocal product, quotient and
// remainder, then the result register, before its result is offered.
// Throughput: one sample per cycle; the pipeline advances only where a stage has room.
// Reset (asynchronous, active low): phase waiting, both counters, all sums and all offsets
// zero, stable threshold 300 and gravity reference 16384.
`default_nettype none

module imu_zero_offset_calibrator import izoc_pkg::*; #(
  parameter int unsigned STABLE_COUNT  = STABLE_COUNT_DEF,
  parameter int unsigned AVERAGE_COUNT = AVERAGE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  izoc_smp_if.sink    smp_i,
  izoc_res_if.source  res_o,
  izoc_cfg_if.sink    cfg_i
);

  logic signed [SMP_W-1:0] thr_q;
  logic [GRAV_W-1:0]       grav_q;

  logic     v1_q, v2_q, v3_q, v4_q, v5_q;
  logic     ld2, ld3, ld4, ld5;
  logic     free1, free2, free3, free4, free5;

  logic     restart1_q;
  smp_vec_t smp1_q;

  phase_e   phase2;
  logic     done2;
  sum_t     sums2 [N_AXES];

  phase_e   phase3_q, phase4_q, phase5_q;
  logic     done3_q, done4_q;

  div_ctrl_t div_ctrl;
  off_t      off4 [N_AXES];
  off_t      offsets_q [N_AXES];

  // Each stage takes a new transaction when it is empty or its own one moves on.
  assign free5 = !v5_q || res_o.ready;
  assign ld5   = v4_q && free5;
  assign free4 = !v4_q || ld5;
  assign ld4   = v3_q && free4;
  assign free3 = !v3_q || ld4;
  assign ld3   = v2_q && free3;
  assign free2 = !v2_q || ld3;
  assign ld2   = v1_q && free2;
  assign free1 = !v1_q || ld2;

  assign smp_i.ready = free1;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RST;
      grav_q <= GRAVITY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_THRESHOLD: thr_q  <= $signed(cfg_i.data);
        CFG_GRAVITY:   grav_q <= cfg_i.data[GRAV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (free1) v1_q <= smp_i.valid;
      if (free2) v2_q <= v1_q;
      if (free3) v3_q <= v2_q;
      if (free4) v4_q <= v3_q;
      if (free5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.valid && free1) begin
      restart1_q          <= smp_i.restart;
      smp1_q[AX_RATE_X]   <= smp_i.rate_x;
      smp1_q[AX_RATE_Y]   <= smp_i.rate_y;
      smp1_q[AX_RATE_Z]   <= smp_i.rate_z;
      smp1_q[AX_ACC_X]    <= smp_i.acc_x;
      smp1_q[AX_ACC_Y]    <= smp_i.acc_y;
      smp1_q[AX_ACC_Z]    <= smp_i.acc_z;
    end
  end

  izoc_tracker #(
    .STABLE_COUNT  (STABLE_COUNT),
    .AVERAGE_COUNT (AVERAGE_COUNT)
  ) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (ld2),
    .restart_i (restart1_q),
    .smp_i     (smp1_q),
    .thr_i     (thr_q),
    .grav_i    (grav_q),
    .phase_o   (phase2),
    .done_o    (done2),
    .sums_o    (sums2)
  );

  assign div_ctrl.ld_prod = ld3;
  assign div_ctrl.ld_quot = ld4;

  for (genvar a = 0; a < N_AXES; a++) begin : g_axis
    izoc_div #(
      .AVERAGE_COUNT (AVERAGE_COUNT)
    ) u_div (
      .clk_i  (clk_i),
      .ctrl_i (div_ctrl),
      .sum_i  (sums2[a]),
      .off_o  (off4[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      phase3_q <= phase2;
      done3_q  <= done2;
    end
    if (ld4) begin
      phase4_q <= phase3_q;
      done4_q  <= done3_q;
    end
    if (ld5) begin
      phase5_q <= phase4_q;
    end
  end

  // The offsets double as the result payload; they change only when the
  // completing transaction enters the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_AXES; i++) begin
        offsets_q[i] <= '0;
      end
    end else if (ld5 && done4_q) begin
      offsets_q <= off4;
    end
  end

  assign res_o.valid      = v5_q;
  assign res_o.phase      = phase5_q;
  assign res_o.rate_off_x = offsets_q[AX_RATE_X];
  assign res_o.rate_off_y = offsets_q[AX_RATE_Y];
  assign res_o.rate_off_z = offsets_q[AX_RATE_Z];
  assign res_o.acc_off_x  = offsets_q[AX_ACC_X];
  assign res_o.acc_off_y  = offsets_q[AX_ACC_Y];
  assign res_o.acc_off_z  = offsets_q[AX_ACC_Z];

endmodule

`default_nettype wire

>>> hdl/izoc_checker.sv
`default_nettype none

module izoc_checker import izoc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      smp_valid_i,
  input logic                      smp_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [PHASE_W-1:0]        res_phase_i,
  input logic [N_AXES*OFF_W-1:0]   res_offs_i
);

  // A stalled result keeps being offered.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_phase_i) && $stable(res_offs_i))
    else $error("result payload changed while stalled");

  // New offsets only ever arrive with a result that reports them ready.
  a_offs_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(res_offs_i) |-> res_valid_i && (res_phase_i == PH_READY))
    else $error("offsets changed outside a ready result");

  // With the result register empty the whole pipeline has room for a sample.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> smp_ready_i)
    else $error("sample refused while no result is pending");

  // A sample offered but refused is only possible behind a pending result.
  a_refuse_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i && !smp_ready_i |-> res_valid_i && !res_ready_i)
    else $error("sample refused without a stalled result");

endmodule

bind imu_zero_offset_calibrator izoc_checker u_izoc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .smp_valid_i (smp_i.valid),
  .smp_ready_i (smp_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_phase_i (res_o.phase),
  .res_offs_i  ({res_o.rate_off_x, res_o.rate_off_y, res_o.rate_off_z,
                 res_o.acc_off_x, res_o.acc_off_y, res_o.acc_off_z})
);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import izoc_pkg::*;

  localparam int STABLE_N    = STABLE_COUNT_DEF;
  localparam int AVG_N       = AVERAGE_COUNT_DEF;
  localparam int SUM_HI      = 8388607;
  localparam int SUM_LO      = -8388608;
  localparam int LAT_PAD     = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DIR_N       = 13;

  typedef struct packed {
    logic     restart;
    smp_vec_t axes;
  } cal_sample_t;

  typedef struct packed {
    phase_e   phase;
    smp_vec_t offs;
  } cal_offsets_t;

  typedef struct {
    bit          restart;
    logic [15:0] v[N_AXES];
    bit          known;
    phase_e      ph;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni;

  izoc_smp_if smp();
  izoc_res_if res();
  izoc_cfg_if cfg();

  imu_zero_offset_calibrator #(
    .STABLE_COUNT  (STABLE_N),
    .AVERAGE_COUNT (AVG_N)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .smp_i  (smp),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always #6 clk = ~clk;

  // Calibrator state as this testbench expects it to be.
  phase_e           cal_phase = PH_WAIT;
  logic [CNT_W-1:0] stable_cnt = '0;
  logic [CNT_W-1:0] avg_cnt = '0;
  int               axis_sum[N_AXES] = '{default: 0};
  int               axis_off[N_AXES] = '{default: 0};
  int               thr_cfg = THRESHOLD_RST;
  int               grav_cfg = GRAVITY_RST;

  cal_offsets_t pending_offsets[$];
  int           mismatches = 0;
  int           counted_items = 0;
  int unsigned  cycle_count = 0;
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;

  string axis_label[N_AXES] = '{"rate_off_x", "rate_off_y", "rate_off_z",
                                "acc_off_x", "acc_off_y", "acc_off_z"};

  // Offsets are all zero until a first calibration completes, so these rows carry
  // their expected result directly.
  stim_row_t directed_rows[DIR_N] = '{
    '{1'b1, '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h012C, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h0000, 16'h012C, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h0000, 16'h0000, 16'h012C, 16'h0000, 16'h0000, 16'h0000}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h012B, 16'h012B, 16'h012B, 16'h0000, 16'h0000, 16'h0000}, 1'b1, PH_WAIT},
    '{1'b0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, PH_WAIT},
    '{1'b0, '{16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA}, 1'b1, PH_WAIT},
    '{1'b1, '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h8000, 16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB, 16'h4000}, 1'b1, PH_WAIT},
    '{1'b0, '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'hC000}, 1'b1, PH_WAIT}
  };

  task automatic report(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic cal_offsets_t calibrate_step(input cal_sample_t s);
    cal_offsets_t r;
    int           v;
    if (s.restart) begin
      cal_phase  = PH_WAIT;
      stable_cnt = '0;
      avg_cnt    = '0;
      for (int i = 0; i < N_AXES; i++) axis_sum[i] = 0;
    end else begin
      case (cal_phase)
        PH_WAIT: begin
          if ($signed(s.axes[AX_RATE_X]) < thr_cfg && $signed(s.axes[AX_RATE_Y]) < thr_cfg &&
              $signed(s.axes[AX_RATE_Z]) < thr_cfg) begin
            stable_cnt = stable_cnt + 1'b1;
            if (stable_cnt >= STABLE_N) cal_phase = PH_AVG;
          end
        end
        PH_AVG: begin
          for (int i = 0; i < N_AXES; i++) begin
            v = $signed(s.axes[i]);
            if (i == AX_ACC_Z) v = v - grav_cfg;
            v = axis_sum[i] + v;
            axis_sum[i] = (v > SUM_HI) ? SUM_HI : (v < SUM_LO) ? SUM_LO : v;
          end
          avg_cnt = avg_cnt + 1'b1;
          if (avg_cnt >= AVG_N) begin
            for (int i = 0; i < N_AXES; i++) begin
              v = axis_sum[i] / AVG_N;
              axis_off[i] = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
            end
            cal_phase = PH_READY;
          end
        end
        default: ;
      endcase
    end
    r.phase = cal_phase;
    for (int i = 0; i < N_AXES; i++) r.offs[i] = 16'(axis_off[i]);
    return r;
  endfunction

  function automatic logic [15:0] any_val();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] pick_in(input int lo, input int hi);
    int r;
    case ($urandom_range(4))
      0: r = lo;
      1: r = hi;
      default: r = lo + int'($urandom_range(hi - lo));
    endcase
    return 16'(r);
  endfunction

  function automatic cal_sample_t random_sample(input bit restart);
    cal_sample_t s;
    s.restart = restart;
    for (int i = 0; i < N_AXES; i++) s.axes[i] = any_val();
    return s;
  endfunction

  // All three rates below the threshold; only possible while the threshold is above the minimum.
  function automatic cal_sample_t stable_sample();
    cal_sample_t s;
    s = random_sample(1'b0);
    s.axes[AX_RATE_X] = pick_in(-32768, thr_cfg - 1);
    s.axes[AX_RATE_Y] = pick_in(-32768, thr_cfg - 1);
    s.axes[AX_RATE_Z] = pick_in(-32768, thr_cfg - 1);
    return s;
  endfunction

  function automatic cal_sample_t unstable_sample();
    cal_sample_t s;
    s = random_sample(1'b0);
    s.axes[$urandom_range(AX_RATE_Z)] = pick_in(thr_cfg, 32767);
    return s;
  endfunction

  // Entered and left at a falling edge; valid stays high on return so that
  // back-to-back transactions need no extra assignment.
  task automatic send_sample(input cal_sample_t s, input bit use_known,
                             input cal_offsets_t known_exp);
    cal_offsets_t want;
    while (!no_idle && $urandom_range(99) < 33) begin
      smp.valid <= 1'b0;
      @(negedge clk);
    end
    smp.valid   <= 1'b1;
    smp.restart <= s.restart;
    smp.rate_x  <= s.axes[AX_RATE_X];
    smp.rate_y  <= s.axes[AX_RATE_Y];
    smp.rate_z  <= s.axes[AX_RATE_Z];
    smp.acc_x   <= s.axes[AX_ACC_X];
    smp.acc_y   <= s.axes[AX_ACC_Y];
    smp.acc_z   <= s.axes[AX_ACC_Z];
    do @(posedge clk); while (!smp.ready);
    if (s.restart || cal_phase != PH_READY) counted_items++;
    want = calibrate_step(s);
    pending_offsets.push_back(use_known ? known_exp : want);
    @(negedge clk);
  endtask

  task automatic send_random(input cal_sample_t s);
    send_sample(s, 1'b0, '0);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    @(negedge clk);
    while (pending_offsets.size() != 0) @(negedge clk);
    repeat (LAT_PAD) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_THRESHOLD: thr_cfg = $signed(value);
      CFG_GRAVITY:   grav_cfg = value[GRAV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // One calibration attempt: mostly well formed, sometimes cut short by a restart.
  task automatic run_sequence();
    int       n;
    bit       pinned;
    smp_vec_t pinned_vals;
    cal_sample_t s;
    if ($urandom_range(99) < 85) send_random(random_sample(1'b1));
    n = 0;
    while (cal_phase == PH_WAIT && n < 3 * STABLE_N) begin
      if ($urandom_range(99) < 2) send_random(random_sample(1'b1));
      else if (thr_cfg > -32768 && $urandom_range(99) < 80) send_random(stable_sample());
      else send_random(unstable_sample());
      n++;
    end
    // Pinning every axis to a rail drives the offsets to their limits; accel z, net of gravity, can go into saturation.
    pinned = $urandom_range(99) < 20;
    for (int i = 0; i < N_AXES; i++) pinned_vals[i] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    while (cal_phase == PH_AVG) begin
      if ($urandom_range(999) < 4) begin
        send_random(random_sample(1'b1));
      end else begin
        s = random_sample(1'b0);
        if (pinned) s.axes = pinned_vals;
        send_random(s);
      end
    end
    if (cal_phase == PH_READY) repeat ($urandom_range(1, 4)) send_random(random_sample(1'b0));
  endtask

  always @(posedge clk) begin
    cal_offsets_t want;
    logic [OFF_W-1:0] got[N_AXES];
    if (rst_ni && res.valid && res.ready) begin
      if (pending_offsets.size() == 0) begin
        report("result transaction with no sample waiting");
      end else begin
        want = pending_offsets.pop_front();
        got = '{res.rate_off_x, res.rate_off_y, res.rate_off_z,
                res.acc_off_x, res.acc_off_y, res.acc_off_z};
        if (res.phase !== want.phase)
          report($sformatf("phase got %0d want %0d", res.phase, want.phase));
        for (int i = 0; i < N_AXES; i++)
          if (got[i] !== want.offs[i])
            report($sformatf("%s got %0d want %0d", axis_label[i],
                             $signed(got[i]), $signed(want.offs[i])));
      end
    end
  end

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= no_idle || ($urandom_range(99) >= 33);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    cal_sample_t  s;
    cal_offsets_t known_exp;
    logic [15:0]  t;
    logic [15:0]  g;
    int           quota;
    bit           paused;
    smp.valid   = 1'b0;
    smp.restart = 1'b0;
    smp.rate_x  = '0;
    smp.rate_y  = '0;
    smp.rate_z  = '0;
    smp.acc_x   = '0;
    smp.acc_y   = '0;
    smp.acc_z   = '0;
    cfg.valid   = 1'b0;
    cfg.index   = CFG_THRESHOLD;
    cfg.data    = '0;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    for (int k = 0; k < DIR_N; k++) begin
      s.restart = directed_rows[k].restart;
      for (int i = 0; i < N_AXES; i++) s.axes[i] = directed_rows[k].v[i];
      known_exp.phase = directed_rows[k].ph;
      known_exp.offs  = '0;
      send_sample(s, directed_rows[k].known, known_exp);
    end

    paused = 1'b0;
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin t = 16'h7FFF; g = 16'hFFFF; quota = 400; end
        1: begin t = 16'h8000; g = 16'h0000; quota = 120; end
        2: begin t = THRESHOLD_RST; g = 16'(GRAVITY_RST); quota = 400; end
        3: begin t = 16'($urandom_range(16'hFFFF)); g = 16'($urandom_range(16'hFFFF)); quota = 430; end
        default: begin t = 16'h0000; g = 16'($urandom_range(16'hFFFF)); quota = 400; end
      endcase
      write_reg(CFG_THRESHOLD, t);
      write_reg(CFG_GRAVITY, g);
      cfg.valid <= 1'b0;
      no_idle  = (p == 2);
      hold_req = (p == 3);
      counted_items = 0;
      while (counted_items < quota) begin
        if (p == 4 && !paused && counted_items >= 200) begin
          drain();
          paused = 1'b1;
        end
        run_sequence();
      end
    end

    drain();
    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
